// File: rtl/core/sha1_message_hash_defines.svh
// Assertion macros shared by the SHA-1 hash RTL.
// Users must have i_clk and i_rst_n in scope.
`ifndef SHA1_MESSAGE_HASH_DEFINES_SVH
`define SHA1_MESSAGE_HASH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SHA1MH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHA1MH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sha1mh_pkg.sv
// Types, constants and helpers for the SHA-1 message hash.
// No dependencies.
package sha1mh_pkg;

    typedef logic [4:0][31:0] t_chain;

    typedef enum logic [2:0] {
        S_FILL,
        S_PAD,
        S_LEN,
        S_LOAD,
        S_RND,
        S_FIN,
        S_OUT
    } t_state;

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic       load;     // take a..e from chaining value
        logic       step;     // execute one round
        logic       use_mem;  // round word comes from block RAM
        logic [1:0] grp;      // round group, selects f and K
    } t_rnd_ctl;

    localparam t_chain IV_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] f_k(input logic [1:0] grp);
        logic [31:0] k;
        case (grp)
            2'd0:    k = 32'h5A827999;
            2'd1:    k = 32'h6ED9EBA1;
            2'd2:    k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/core/sha1mh_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sha1mh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sha1mh_round.sv
// SHA-1 round datapath: working variables a..e and the 16-word schedule window.
// Depends on sha1mh_pkg.
module sha1mh_round
    import sha1mh_pkg::*;
(
    input  logic        i_clk,
    input  t_rnd_ctl    i_ctl,
    input  t_chain      i_chain,
    input  logic [31:0] i_mem_word,
    output t_chain      o_abcde
);

    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];   // r_w[j] holds w[r-16+j]
    logic [31:0] w_cur;
    logic [31:0] w_mix;
    logic [31:0] f_val;
    logic [31:0] t_sum;

    assign w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_cur = i_ctl.use_mem ? i_mem_word : {w_mix[30:0], w_mix[31]};

    always_comb begin
        case (i_ctl.grp)
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd2:    f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            default: f_val = r_b ^ r_c ^ r_d;
        endcase
    end

    assign t_sum = {r_a[26:0], r_a[31:27]} + f_val + r_e + f_k(i_ctl.grp) + w_cur;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_chain[0];
            r_b <= i_chain[1];
            r_c <= i_chain[2];
            r_d <= i_chain[3];
            r_e <= i_chain[4];
        end else if (i_ctl.step) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= t_sum;
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= w_cur;
        end
    end

    assign o_abcde = {r_e, r_d, r_c, r_b, r_a};

endmodule

// File: rtl/core/sha1_message_hash.sv
// SHA-1 message hash top level: byte packing, padding, sequencing, digest output.
// Depends on sha1mh_pkg, sha1mh_ram, sha1mh_round, sha1_message_hash_defines.svh.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one word per handshake: a message
//   byte, a byte-valid flag and a last flag. Byte-valid 0 with last 0 is a
//   no-op; byte-valid 0 with last 1 closes the message without adding a byte.
//   Output channel (o_valid / i_ready) returns five 32-bit digest words, H0
//   first, with the word index and a last flag on the fifth word.
//   Bytes are taken one per cycle while the input is open. Each completed
//   64-byte block stalls the input during its compression: a load step,
//   80 rounds at one per cycle and a chain add, done by the single round
//   unit fed from the single RAM read port.
//   After the last word, padding fills each padded block and writes 2 length
//   words, then one or two compressions run before the first digest word.
//   The output waits for i_ready; the input stays closed until all five words
//   are taken. Reset loads the initial chaining value and clears the length
//   and byte count; block RAM contents are not cleared.
`include "sha1_message_hash_defines.svh"

module sha1_message_hash
    import sha1mh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_valid,
    input  logic        i_msg_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [31:0] r_acc, n_acc;
    logic [63:0] r_bitlen, n_bitlen;
    logic        r_pad, n_pad;
    logic        r_last, n_last;
    logic        r_final, n_final;
    logic [6:0]  r_rnd, n_rnd;
    logic [2:0]  r_oidx, n_oidx;
    t_chain      r_chain, n_chain;

    logic        put_en;
    logic [7:0]  put_byte;
    logic [31:0] acc_put;
    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata;
    logic [3:0]  ram_raddr;
    logic [31:0] ram_rdata;
    t_rnd_ctl    rnd_ctl;
    t_chain      abcde;

    sha1mh_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sha1mh_round u_round (
        .i_clk      (i_clk),
        .i_ctl      (rnd_ctl),
        .i_chain    (r_chain),
        .i_mem_word (ram_rdata),
        .o_abcde    (abcde)
    );

    // Big-endian byte insert into the word accumulator.
    always_comb begin
        case (r_fill[1:0])
            2'd0:    acc_put = {put_byte, 24'd0};
            2'd1:    acc_put = r_acc | {8'd0, put_byte, 16'd0};
            2'd2:    acc_put = r_acc | {16'd0, put_byte, 8'd0};
            default: acc_put = r_acc | {24'd0, put_byte};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_fill   <= '0;
            r_bitlen <= '0;
            r_pad    <= 1'b0;
            r_last   <= 1'b0;
            r_final  <= 1'b0;
            r_rnd    <= '0;
            r_oidx   <= '0;
            r_chain  <= IV_INIT;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_bitlen <= n_bitlen;
            r_pad    <= n_pad;
            r_last   <= n_last;
            r_final  <= n_final;
            r_rnd    <= n_rnd;
            r_oidx   <= n_oidx;
            r_chain  <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_acc    = r_acc;
        n_bitlen = r_bitlen;
        n_pad    = r_pad;
        n_last   = r_last;
        n_final  = r_final;
        n_rnd    = r_rnd;
        n_oidx   = r_oidx;
        n_chain  = r_chain;
        o_ready  = 1'b0;
        o_valid  = 1'b0;
        put_en   = 1'b0;
        put_byte = 8'd0;
        ram_we   = 1'b0;
        ram_waddr = r_fill[5:2];
        ram_wdata = acc_put;
        ram_raddr = 4'd0;
        rnd_ctl  = '0;

        if (r_rnd < 7'd20) begin
            rnd_ctl.grp = 2'd0;
        end else if (r_rnd < 7'd40) begin
            rnd_ctl.grp = 2'd1;
        end else if (r_rnd < 7'd60) begin
            rnd_ctl.grp = 2'd2;
        end else begin
            rnd_ctl.grp = 2'd3;
        end

        unique case (r_state)
            S_FILL: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_byte_valid) begin
                        put_en   = 1'b1;
                        put_byte = i_msg_byte;
                        n_bitlen = r_bitlen + 64'd8;
                    end
                    if (i_msg_last) begin
                        n_last = 1'b1;
                    end
                    if (i_byte_valid && r_fill == 6'd63) begin
                        n_final = 1'b0;
                        n_state = S_LOAD;
                    end else if (i_msg_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (!r_pad) begin
                    put_en   = 1'b1;
                    put_byte = PAD_BYTE;
                    n_pad    = 1'b1;
                    if (r_fill == 6'd63) begin
                        n_state = S_LOAD;
                    end
                end else if (r_fill == 6'd56) begin
                    n_state = S_LEN;
                end else if (r_fill[1:0] == 2'd0) begin
                    // aligned: write a whole zero word
                    ram_we    = 1'b1;
                    ram_wdata = 32'd0;
                    n_fill    = r_fill + 6'd4;
                    if (r_fill == 6'd60) begin
                        n_state = S_LOAD;
                    end
                end else begin
                    put_en = 1'b1;
                    if (r_fill == 6'd63) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LEN: begin
                ram_we = 1'b1;
                if (r_fill == 6'd56) begin
                    ram_waddr = 4'd14;
                    ram_wdata = r_bitlen[63:32];
                    n_fill    = 6'd60;
                end else begin
                    ram_waddr = 4'd15;
                    ram_wdata = r_bitlen[31:0];
                    n_fill    = 6'd0;
                    n_final   = 1'b1;
                    n_state   = S_LOAD;
                end
            end
            S_LOAD: begin
                rnd_ctl.load = 1'b1;
                ram_raddr    = 4'd0;
                n_rnd        = 7'd0;
                n_state      = S_RND;
            end
            S_RND: begin
                rnd_ctl.step    = 1'b1;
                rnd_ctl.use_mem = (r_rnd < 7'd16);
                ram_raddr       = r_rnd[3:0] + 4'd1;
                n_rnd           = r_rnd + 7'd1;
                if (r_rnd == 7'd79) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                for (int i = 0; i < 5; i++) begin
                    n_chain[i] = r_chain[i] + abcde[i];
                end
                if (r_final) begin
                    n_oidx  = 3'd0;
                    n_state = S_OUT;
                end else if (r_last) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (r_oidx == 3'd4) begin
                        n_chain  = IV_INIT;
                        n_bitlen = '0;
                        n_fill   = '0;
                        n_pad    = 1'b0;
                        n_last   = 1'b0;
                        n_final  = 1'b0;
                        n_state  = S_FILL;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: n_state = S_FILL;
        endcase

        if (put_en) begin
            n_acc  = acc_put;
            n_fill = r_fill + 6'd1;
            if (r_fill[1:0] == 2'd3) begin
                ram_we = 1'b1;
            end
        end
    end

    assign o_digest_word = r_chain[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_digest_last = (r_oidx == 3'd4);

    `SHA1MH_ASSERT_NOW(a_no_write_in_compress, r_state == S_LOAD || r_state == S_RND,
        !ram_we, "block RAM written during compression")
    `SHA1MH_ASSERT_NEXT(a_rounds_end, r_state == S_RND && r_rnd == 7'd79,
        r_state == S_FIN, "round count did not end at 80")
    `SHA1MH_ASSERT_NOW(a_len_fill, r_state == S_LEN,
        r_fill == 6'd56 || r_fill == 6'd60, "length written at wrong fill")
    `SHA1MH_ASSERT_NEXT(a_msg_restart, o_valid && i_ready && o_digest_last,
        r_bitlen == 64'd0 && r_chain == IV_INIT && r_fill == 6'd0,
        "state not restored after digest")
    `SHA1MH_ASSERT_NOW(a_out_index, o_valid, r_oidx <= 3'd4 && !o_ready,
        "output index out of range or input open")

endmodule
